@@ sv/cps_pkg.sv @@
// shared types and constants for the coulomb potential sum block
`default_nettype none
package cps_pkg;

  localparam int MAX_NUCLEI_DEF = 64;

  localparam int MAG_W  = 33;  // magnitude of a coordinate difference
  localparam int SQ_W   = 68;  // sum of three squares
  localparam int ROOT_W = 34;  // integer square root
  localparam int NUM_W  = 40;  // charge scaled by 2^24
  localparam int POT_W  = 48;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        charge;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [POT_W-1:0] potential;
    logic             saturated;
  } out_t;

  // one finished term from the arithmetic unit
  typedef struct packed {
    logic             done;
    logic             zero;
    logic [NUM_W-1:0] term;
  } term_t;

endpackage
`default_nettype wire

@@ sv/cps_term.sv @@
// iterative unit: squared distance, square root and division for one charge
`default_nettype none
module cps_term (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [cps_pkg::MAG_W-1:0] mag_x,
  input  wire logic [cps_pkg::MAG_W-1:0] mag_y,
  input  wire logic [cps_pkg::MAG_W-1:0] mag_z,
  input  wire logic [15:0]             charge,
  output cps_pkg::term_t               result
);

  localparam int MW = cps_pkg::MAG_W;
  localparam int SW = cps_pkg::SQ_W;
  localparam int RW = cps_pkg::ROOT_W;
  localparam int NW = cps_pkg::NUM_W;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_SQ   = 5'b00010,
    T_SQRT = 5'b00100,
    T_DIV  = 5'b01000,
    T_DONE = 5'b10000
  } tstate_t;

  tstate_t state;
  logic [5:0]    step;
  logic [1:0]    axis;
  logic [1:0]    part;
  logic [MW-1:0] mx, my, mz;
  logic [SW-1:0] sq;
  logic [RW+1:0] rem_s;
  logic [RW-1:0] root;
  logic [NW-1:0] num;
  logic [RW-1:0] rem_d;

  // squaring operands: magnitude split into 17 high and 16 low bits
  logic [MW-1:0] mag_sel;
  logic [16:0]   op_a, op_b;
  logic [33:0]   prod;
  logic [SW-1:0] prod_sh;

  always_comb begin
    case (axis)
      2'd0:    mag_sel = mx;
      2'd1:    mag_sel = my;
      default: mag_sel = mz;
    endcase
    case (part)
      2'd0: begin
        op_a = mag_sel[32:16];
        op_b = mag_sel[32:16];
      end
      2'd1: begin
        op_a = mag_sel[32:16];
        op_b = {1'b0, mag_sel[15:0]};
      end
      default: begin
        op_a = {1'b0, mag_sel[15:0]};
        op_b = {1'b0, mag_sel[15:0]};
      end
    endcase
    prod = op_a * op_b;
    case (part)
      2'd0:    prod_sh = {prod, 34'd0} >> 2;
      2'd1:    prod_sh = {17'd0, prod, 17'd0};
      default: prod_sh = {34'd0, prod};
    endcase
  end

  // one square root digit per cycle
  logic [RW+1:0] rem_s_sh, trial;
  logic          sqrt_ge;
  assign rem_s_sh = {rem_s[RW-1:0], sq[SW-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign sqrt_ge  = rem_s_sh >= trial;

  // one quotient bit per cycle
  logic [RW:0] rem_d_sh;
  logic        div_ge;
  assign rem_d_sh = {rem_d, num[NW-1]};
  assign div_ge   = rem_d_sh >= {1'b0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: if (start) state <= T_SQ;
        T_SQ:   if (axis == 2'd2 && part == 2'd2) state <= T_SQRT;
        T_SQRT: if (step == 6'(RW - 1)) state <= (root == '0 && !sqrt_ge) ? T_DONE : T_DIV;
        T_DIV:  if (step == 6'(NW - 1)) state <= T_DONE;
        T_DONE: state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        mx    <= mag_x;
        my    <= mag_y;
        mz    <= mag_z;
        sq    <= '0;
        axis  <= 2'd0;
        part  <= 2'd0;
        step  <= '0;
        rem_s <= '0;
        root  <= '0;
        rem_d <= '0;
        num   <= {charge, 24'd0};
      end
      T_SQ: begin
        sq <= sq + prod_sh;
        if (part == 2'd2) begin
          part <= 2'd0;
          axis <= axis + 2'd1;
        end else begin
          part <= part + 2'd1;
        end
      end
      T_SQRT: begin
        sq <= sq << 2;
        if (sqrt_ge) begin
          rem_s <= rem_s_sh - trial;
          root  <= {root[RW-2:0], 1'b1};
        end else begin
          rem_s <= rem_s_sh;
          root  <= {root[RW-2:0], 1'b0};
        end
        step <= (step == 6'(RW - 1)) ? '0 : step + 6'd1;
      end
      T_DIV: begin
        if (div_ge) begin
          rem_d <= RW'(rem_d_sh - {1'b0, root});
          num   <= {num[NW-2:0], 1'b1};
        end else begin
          rem_d <= rem_d_sh[RW-1:0];
          num   <= {num[NW-2:0], 1'b0};
        end
        step <= step + 6'd1;
      end
      default: ;
    endcase
  end

  assign result.done = (state == T_DONE);
  assign result.zero = (root == '0);
  assign result.term = num;

endmodule
`default_nettype wire

@@ sv/coulomb_potential_sum.sv @@
// coulomb potential sum: top level with charge memory and sequencer
// load, clear and unused commands give no result
// evaluate shows its word once every one of the N stored charges has been summed
// per charge: one read, one difference, 9 partial products, 34 root digits, 40 quotient bits and a
// handoff (no quotient bits at zero distance); no word is taken meanwhile, a waiting result holds the end
// synchronous active-high reset empties the table and drops any pending result
`default_nettype none
module coulomb_potential_sum #(
  parameter int MAX_NUCLEI = cps_pkg::MAX_NUCLEI_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cps_pkg::in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cps_pkg::out_t out_data
);

  localparam int AW = (MAX_NUCLEI > 1) ? $clog2(MAX_NUCLEI) : 1;
  localparam int CW = $clog2(MAX_NUCLEI + 1);
  localparam int MW = cps_pkg::MAG_W;
  localparam int PW = cps_pkg::POT_W;
  localparam int EW = 16 + 3 * 32;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_DIFF = 5'b00100,
    S_WAIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic signed [31:0] qx, qy, qz;
  logic [PW:0]   sum;
  logic          sat;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // charge memory: charge and position per entry
  logic [EW-1:0] mem [MAX_NUCLEI];
  logic [EW-1:0] rd;
  logic          wr_en;

  assign wr_en = accept && in_data.cmd == cps_pkg::CMD_LOAD && count < CW'(MAX_NUCLEI);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {in_data.charge, in_data.coord_x, in_data.coord_y, in_data.coord_z};
    end
    rd <= mem[idx[AW-1:0]];
  end

  // magnitudes of the differences to the query point
  logic signed [32:0] dx, dy, dz;
  logic [MW-1:0] mag_x, mag_y, mag_z;

  always_comb begin
    dx = 33'(signed'(rd[95:64])) - 33'(qx);
    dy = 33'(signed'(rd[63:32])) - 33'(qy);
    dz = 33'(signed'(rd[31:0]))  - 33'(qz);
    mag_x = dx[32] ? MW'(-dx) : MW'(dx);
    mag_y = dy[32] ? MW'(-dy) : MW'(dy);
    mag_z = dz[32] ? MW'(-dz) : MW'(dz);
  end

  cps_pkg::term_t term;

  cps_term u_term (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DIFF),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .mag_z  (mag_z),
    .charge (rd[EW-1 -: 16]),
    .result (term)
  );

  logic [PW:0] sum_next;
  assign sum_next = sum + {{(PW + 1 - cps_pkg::NUM_W){1'b0}}, term.term};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result word handshake
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.cmd)
              cps_pkg::CMD_LOAD:  if (wr_en) count <= count + CW'(1);
              cps_pkg::CMD_CLEAR: count <= '0;
              cps_pkg::CMD_EVAL:  state <= (count == '0) ? S_DONE : S_READ;
              default: ;
            endcase
          end
        end
        S_READ: state <= S_DIFF;
        S_DIFF: state <= S_WAIT;
        S_WAIT: if (term.done) state <= (idx + CW'(1) == count) ? S_DONE : S_READ;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query point, index and running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      qx  <= in_data.coord_x;
      qy  <= in_data.coord_y;
      qz  <= in_data.coord_z;
      idx <= '0;
      sum <= '0;
      sat <= 1'b0;
    end
    if (state == S_WAIT && term.done) begin
      idx <= idx + CW'(1);
      if (term.zero) begin
        sat <= 1'b1;
      end else if (!sat) begin
        sum <= sum_next;
        if (sum_next[PW]) sat <= 1'b1;
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.potential <= sat ? {PW{1'b1}} : sum[PW-1:0];
      out_data.saturated <= sat;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NUCLEI)) else $error("charge count past table size");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    term.done |-> state == S_WAIT) else $error("term finished outside wait");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |-> out_data.potential == {PW{1'b1}})
    else $error("saturated result not all ones");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> idx < count) else $error("read past stored charges");

endmodule
`default_nettype wire

@@ test/coulomb_potential_sum_tb.sv @@
// testbench for coulomb_potential_sum: directed table, random command sequences, scoreboard
`timescale 1ns / 100ps
module coulomb_potential_sum_tb;

  localparam int NUC_DEPTH = 64;
  localparam int ITEM_GOAL = 1050;
  localparam int CYCLE_LIMIT = 30000000;
  localparam logic [cps_pkg::POT_W-1:0] POT_FULL = '1;
  localparam int SQ_W = cps_pkg::SQ_W;
  localparam int ROOT_W = cps_pkg::ROOT_W;
  localparam int POT_W = cps_pkg::POT_W;

  localparam cps_pkg::cmd_t C_LOAD  = cps_pkg::CMD_LOAD;
  localparam cps_pkg::cmd_t C_CLEAR = cps_pkg::CMD_CLEAR;
  localparam cps_pkg::cmd_t C_EVAL  = cps_pkg::CMD_EVAL;
  localparam cps_pkg::cmd_t C_NONE  = cps_pkg::CMD_NONE;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cps_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cps_pkg::out_t out_data;

  coulomb_potential_sum dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // local copy of the charge table
  logic [15:0] nuc_charge[NUC_DEPTH];
  logic signed [31:0] nuc_x[NUC_DEPTH];
  logic signed [31:0] nuc_y[NUC_DEPTH];
  logic signed [31:0] nuc_z[NUC_DEPTH];
  int nuc_count = 0;

  cps_pkg::out_t potential_q[$];
  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned cycles = 0;

  // squared distance along one axis, exact
  function automatic logic [SQ_W-1:0] axis_sq(logic signed [31:0] a, logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32]) d = -d;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // sum of Z / r over the stored charges, Q32.16, saturated
  function automatic cps_pkg::out_t coulomb_sum(logic signed [31:0] qx,
                                                logic signed [31:0] qy,
                                                logic signed [31:0] qz);
    logic [63:0] acc;
    logic sat;
    logic [SQ_W-1:0] dist2;
    logic [ROOT_W-1:0] root, cand;
    cps_pkg::out_t res;
    acc = '0;
    sat = 1'b0;
    for (int n = 0; n < nuc_count; n++) begin
      dist2 = axis_sq(nuc_x[n], qx) + axis_sq(nuc_y[n], qy) + axis_sq(nuc_z[n], qz);
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        cand = root | (ROOT_W'(1) << b);
        if (SQ_W'(cand) * SQ_W'(cand) <= dist2) root = cand;
      end
      if (root == '0) begin
        sat = 1'b1;
      end else begin
        acc += 64'({nuc_charge[n], 24'b0}) / 64'(root);
        if (acc > 64'(POT_FULL)) sat = 1'b1;
      end
    end
    res.potential = sat ? POT_FULL : acc[POT_W-1:0];
    res.saturated = sat;
    return res;
  endfunction

  // send one word, then update the local table and queue any expected result
  task automatic apply(cps_pkg::in_t w, bit typed = 1'b0, cps_pkg::out_t typed_res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    case (cps_pkg::cmd_t'(w.cmd))
      C_LOAD: begin
        if (nuc_count < NUC_DEPTH) begin
          nuc_charge[nuc_count] = w.charge;
          nuc_x[nuc_count] = w.coord_x;
          nuc_y[nuc_count] = w.coord_y;
          nuc_z[nuc_count] = w.coord_z;
          nuc_count++;
        end
      end
      C_CLEAR: nuc_count = 0;
      C_EVAL: potential_q.push_back(typed ? typed_res
                                          : coulomb_sum(w.coord_x, w.coord_y, w.coord_z));
      default: ;
    endcase
    if (cps_pkg::cmd_t'(w.cmd) != C_NONE) items_sent++;
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    cps_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (potential_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        want = potential_q.pop_front();
        if (out_data.potential !== want.potential || out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected potential %h sat %b, got %h sat %b",
                     want.potential, want.saturated, out_data.potential, out_data.saturated);
        end
      end
    end
  end

  // run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL coulomb_potential_sum");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'($urandom_range(0, 32'h40000))
                                  : -32'($urandom_range(0, 32'h40000));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(1) ? 32'($urandom_range(0, 32'h100_0000))
                                        : -32'($urandom_range(0, 32'h100_0000));
    endcase
  endfunction

  function automatic cps_pkg::in_t make_word(cps_pkg::cmd_t c);
    cps_pkg::in_t w;
    w.cmd = c;
    w.charge = $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom);
    w.coord_x = rand_coord();
    w.coord_y = rand_coord();
    w.coord_z = rand_coord();
    return w;
  endfunction

  // one random sequence: optional clear, loads, evaluations, then an optional unused command
  task automatic random_batch();
    cps_pkg::in_t w;
    int loads, evals, pick;
    if ($urandom_range(99) < 10) apply(make_word(C_CLEAR));
    loads = ($urandom_range(99) < 3) ? NUC_DEPTH + 3 : $urandom_range(0, 6);
    for (int i = 0; i < loads; i++) apply(make_word(C_LOAD));
    evals = $urandom_range(1, 3);
    for (int i = 0; i < evals; i++) begin
      w = make_word(C_EVAL);
      // land on a stored charge now and then
      if (nuc_count > 0 && $urandom_range(99) < 25) begin
        pick = $urandom_range(0, nuc_count - 1);
        w.coord_x = nuc_x[pick];
        w.coord_y = nuc_y[pick];
        w.coord_z = nuc_z[pick];
      end
      apply(w);
    end
    if ($urandom_range(99) < 5) apply(make_word(C_NONE));
  endtask

  typedef struct {
    cps_pkg::in_t  word;
    bit            typed;
    cps_pkg::out_t res;
  } stim_row_t;

  localparam cps_pkg::out_t RES_ZERO = '{potential: '0, saturated: 1'b0};
  localparam cps_pkg::out_t RES_SAT  = '{potential: '1, saturated: 1'b1};
  localparam cps_pkg::out_t RES_ONE  = '{potential: 48'h1_0000, saturated: 1'b0};

  stim_row_t directed[20] = '{
    '{'{C_EVAL, 16'h0000, 32'sh0, 32'sh0, 32'sh0}, 1'b1, RES_ZERO},
    '{'{C_LOAD, 16'h0100, 32'sh0, 32'sh0, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh1_0000, 32'sh0, 32'sh0}, 1'b1, RES_ONE},
    '{'{C_EVAL, 16'h0000, 32'sh0, 32'sh0, 32'sh0}, 1'b1, RES_SAT},
    '{'{C_LOAD, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, RES_ZERO},
    '{'{C_LOAD, 16'hAAAA, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, RES_ZERO},
    '{'{C_LOAD, 16'h5555, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0000}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1, RES_SAT},
    '{'{C_NONE, 16'hFFFF, 32'sh1234_5678, 32'sh0, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_CLEAR, 16'h0000, 32'sh0, 32'sh0, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh0, 32'sh0, 32'sh0}, 1'b1, RES_ZERO},
    '{'{C_LOAD, 16'h0000, 32'sh0002_0000, 32'shFFFE_0000, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh0002_0000, 32'shFFFE_0000, 32'sh0}, 1'b1, RES_SAT},
    '{'{C_LOAD, 16'h0001, 32'sh0, 32'sh0, 32'sh0000_0001}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh0, 32'sh0, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_CLEAR, 16'hFFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF}, 1'b0, RES_ZERO},
    '{'{C_LOAD, 16'hFFFF, 32'sh0, 32'sh0, 32'sh0}, 1'b0, RES_ZERO},
    '{'{C_EVAL, 16'h0000, 32'sh0, 32'sh0, 32'sh0000_0001}, 1'b0, RES_ZERO}
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    foreach (directed[i]) apply(directed[i].word, directed[i].typed, directed[i].res);

    // random phases with different stall mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 19 : 0;
      while (items_sent < ITEM_GOAL * (phase + 1) / 3) random_batch();
      // hold off until the block has drained
      in_valid <= 1'b0;
      while (potential_q.size() != 0) @(posedge clk);
      @(posedge clk);
    end

    in_valid <= 1'b0;
    while (potential_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && potential_q.size() == 0) begin
      $display("PASS coulomb_potential_sum");
    end else begin
      $display("FAIL coulomb_potential_sum");
    end
    $finish;
  end

endmodule
